FILE: hw/rtl/assert_macros.svh
// Assertion macros shared by the clock time entry RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication on every clock edge outside reset.
`define CTEC_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition leads to a consequence on the following edge.
`define CTEC_ASSERT_NEXT(label, clk, rst, cond, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/ctec_pkg.sv
// Package for the clock time entry controller: key constants, register
// indexes, reset values and digit arithmetic helpers. No dependencies.
`default_nettype none

package ctec_pkg;

   localparam int KEY_W    = 8;
   localparam int VALUE_W  = 12;
   localparam int COUNT_W  = 2;
   localparam int DIGIT_W  = 4;
   localparam int CSR_IDX_W = 2;

   // ASCII codes the block recognizes
   localparam logic [KEY_W-1:0] DIGIT_LO = 8'h30;
   localparam logic [KEY_W-1:0] DIGIT_HI = 8'h39;
   localparam logic [KEY_W-1:0] KEY_NL   = 8'd10;
   localparam logic [KEY_W-1:0] KEY_CR   = 8'd13;

   // Register reset values
   localparam logic [KEY_W-1:0] RESET_KEY_DEFAULT      = 8'd70;
   localparam logic [KEY_W-1:0] SET_CANCEL_KEY_DEFAULT = 8'd67;

   // Register indexes on the csr port
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_HOUR_FORMAT_12 = 2'd0,
      CSR_RESET_KEY      = 2'd1,
      CSR_SET_CANCEL_KEY = 2'd2
   } csr_index_type;

   // Multiply a value by ten with two shifts and an add
   function automatic logic [VALUE_W-1:0] times_ten(input logic [VALUE_W-1:0] value);
      times_ten = {value[VALUE_W-4:0], 3'b000} + {value[VALUE_W-2:0], 1'b0};
   endfunction

   // Smaller of two digits
   function automatic logic [DIGIT_W-1:0] digit_min(input logic [DIGIT_W-1:0] a,
                                                    input logic [DIGIT_W-1:0] b);
      digit_min = (a < b) ? a : b;
   endfunction

   // Larger of two digits
   function automatic logic [DIGIT_W-1:0] digit_max(input logic [DIGIT_W-1:0] a,
                                                    input logic [DIGIT_W-1:0] b);
      digit_max = (a > b) ? a : b;
   endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/clock_time_entry_controller.sv
// Clock time entry controller: key decode, set-mode state and HHMM entry.
// Path: an accepted key word goes through the input register, then the result
// register. Throughput: one key word per cycle while no stall holds; the input
// register takes a new word while a result word waits under stall only if it is empty.
// Reset (synchronous, active high) returns to stand-by with an empty entry,
// no pending reset and register defaults (24-hour, keys 70 and 67).
// Depends on ctec_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module clock_time_entry_controller
   import ctec_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   // key channel
   input  wire logic                 req_valid,
   output      logic                 req_stall,
   input  wire logic [KEY_W-1:0]     req_key_code,
   // result channel
   output      logic                 rsp_valid,
   input  wire logic                 rsp_stall,
   output      logic                 rsp_in_set_mode,
   output      logic [COUNT_W-1:0]   rsp_digits_entered,
   output      logic [VALUE_W-1:0]   rsp_entry_value,
   output      logic                 rsp_time_ready,
   output      logic [VALUE_W-1:0]   rsp_new_time,
   output      logic                 rsp_reset_request,
   output      logic                 rsp_cancelled,
   output      logic                 rsp_unknown_key,
   // configuration write port
   input  wire logic                 csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [KEY_W-1:0]     csr_wdata
);

   // configuration registers
   logic               hour_format_12_ff;
   logic [KEY_W-1:0]   reset_key_ff;
   logic [KEY_W-1:0]   set_cancel_key_ff;

   // input register
   logic               key_valid_ff;
   logic [KEY_W-1:0]   key_ff;

   // controller state
   logic               set_mode_ff, set_mode_in;
   logic [VALUE_W-1:0] acc_ff, acc_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               pending_ff, pending_in;

   // result register
   logic               rsp_valid_ff;
   logic               rsp_ready_ff, rsp_ready_in;
   logic [VALUE_W-1:0] rsp_time_ff, rsp_time_in;
   logic               rsp_rreq_ff, rsp_rreq_in;
   logic               rsp_canc_ff, rsp_canc_in;
   logic               rsp_unk_ff, rsp_unk_in;

   logic               advance;
   logic               accept;

   // move the held key into the result register when it is free or draining
   assign advance   = key_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = key_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   // write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         hour_format_12_ff <= 1'b0;
         reset_key_ff      <= RESET_KEY_DEFAULT;
         set_cancel_key_ff <= SET_CANCEL_KEY_DEFAULT;
      end else if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_HOUR_FORMAT_12: hour_format_12_ff <= csr_wdata[0];
            CSR_RESET_KEY:      reset_key_ff      <= csr_wdata;
            CSR_SET_CANCEL_KEY: set_cancel_key_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // hold the key word until it advances
   always_ff @(posedge clock) begin
      if (reset) begin
         key_valid_ff <= 1'b0;
      end else if (accept) begin
         key_valid_ff <= 1'b1;
      end else if (advance) begin
         key_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         key_ff <= req_key_code;
      end
   end

   // decode the key and compute next state and flags
   always_comb begin
      logic [DIGIT_W-1:0] digit;
      logic               is_digit;
      logic               leave;

      digit    = key_ff[DIGIT_W-1:0];
      is_digit = (key_ff >= DIGIT_LO) && (key_ff <= DIGIT_HI);
      leave    = 1'b0;

      set_mode_in  = set_mode_ff;
      acc_in       = acc_ff;
      count_in     = count_ff;
      pending_in   = pending_ff;
      rsp_ready_in = 1'b0;
      rsp_time_in  = '0;
      rsp_rreq_in  = 1'b0;
      rsp_canc_in  = 1'b0;
      rsp_unk_in   = 1'b0;

      if (key_ff == reset_key_ff) begin
         if (set_mode_ff) begin
            pending_in = 1'b1;
         end else begin
            rsp_rreq_in = 1'b1;
         end
      end else if (key_ff == set_cancel_key_ff) begin
         if (set_mode_ff) begin
            rsp_canc_in = 1'b1;
            leave       = 1'b1;
         end else begin
            set_mode_in = 1'b1;
         end
      end else if (is_digit) begin
         if (set_mode_ff) begin
            case (count_ff)
               2'd0: begin
                  // clamp hour tens by format
                  acc_in   = VALUE_W'(digit_min(hour_format_12_ff ? 4'd1 : 4'd2, digit));
                  count_in = 2'd1;
               end
               2'd1: begin
                  // clamp hour units so the hour stays valid
                  if (hour_format_12_ff) begin
                     digit = (acc_ff == '0) ? digit_max(4'd1, digit) : digit_min(4'd2, digit);
                  end else if (acc_ff == VALUE_W'(2)) begin
                     digit = digit_min(4'd3, digit);
                  end
                  acc_in   = times_ten(acc_ff) + VALUE_W'(digit);
                  count_in = 2'd2;
               end
               2'd2: begin
                  // clamp minute tens
                  acc_in   = times_ten(acc_ff) + VALUE_W'(digit_min(4'd5, digit));
                  count_in = 2'd3;
               end
               default: begin
                  // last digit completes the entry
                  rsp_time_in  = times_ten(acc_ff) + VALUE_W'(digit);
                  rsp_ready_in = 1'b1;
                  leave        = 1'b1;
               end
            endcase
         end
      end else if ((key_ff != KEY_NL) && (key_ff != KEY_CR)) begin
         rsp_unk_in = 1'b1;
      end

      // return to stand-by and release a held reset
      if (leave) begin
         set_mode_in = 1'b0;
         acc_in      = '0;
         count_in    = '0;
         if (pending_ff) begin
            rsp_rreq_in = 1'b1;
            pending_in  = 1'b0;
         end
      end
   end

   // update state on advance
   always_ff @(posedge clock) begin
      if (reset) begin
         set_mode_ff <= 1'b0;
         acc_ff      <= '0;
         count_ff    <= '0;
         pending_ff  <= 1'b0;
      end else if (advance) begin
         set_mode_ff <= set_mode_in;
         acc_ff      <= acc_in;
         count_ff    <= count_in;
         pending_ff  <= pending_in;
      end
   end

   // result word valid: set on advance, drop once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ready_ff <= rsp_ready_in;
         rsp_time_ff  <= rsp_time_in;
         rsp_rreq_ff  <= rsp_rreq_in;
         rsp_canc_ff  <= rsp_canc_in;
         rsp_unk_ff   <= rsp_unk_in;
      end
   end

   // state after the key is part of the result word
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_in_set_mode    = set_mode_ff;
   assign rsp_digits_entered = count_ff;
   assign rsp_entry_value    = acc_ff;
   assign rsp_time_ready     = rsp_ready_ff;
   assign rsp_new_time       = rsp_time_ff;
   assign rsp_reset_request  = rsp_rreq_ff;
   assign rsp_cancelled      = rsp_canc_ff;
   assign rsp_unknown_key    = rsp_unk_ff;

   // checks
   `CTEC_ASSERT(a_standby_clear, clock, reset,
      !set_mode_ff |-> (count_ff == '0 && acc_ff == '0 && !pending_ff),
      "stand-by with a partial entry or held reset")
   `CTEC_ASSERT(a_done_clears, clock, reset,
      (rsp_valid_ff && (rsp_ready_ff || rsp_canc_ff)) |-> (!set_mode_ff && count_ff == '0),
      "completed or cancelled entry left set mode active")
   `CTEC_ASSERT(a_time_only_ready, clock, reset,
      (rsp_valid_ff && !rsp_ready_ff) |-> (rsp_time_ff == '0),
      "new time nonzero without time ready")
   `CTEC_ASSERT_NEXT(a_state_holds, clock, reset,
      !advance, $stable(set_mode_ff) && $stable(acc_ff) && $stable(count_ff),
      "controller state moved without an advancing key")

endmodule

`default_nettype wire
